/* design/mts_pkg.sv */
// Types, codes and constants shared by the min-tracking stack files.
package mts_pkg;

    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 34;
    localparam int CNT_W   = 9;

    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 9'd256;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] current_minimum;
        logic [CNT_W-1:0]         entry_count;
        logic [1:0]               status;
    } t_out_item;

    // Shift command broadcast to every cell of the stack chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

/* design/mts_stream_if.sv */
// Valid/ready stream interfaces for the request and result channels.
interface mts_in_if;
    import mts_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mts_out_if;
    import mts_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/mts_cell.sv */
// One stack cell: holds one encoded entry and shifts with its neighbors.
module mts_cell (
    input  logic                              i_clk,
    input  mts_pkg::t_shift_ctl               i_ctl,
    input  logic signed [mts_pkg::ENTRY_W-1:0] i_from_up,
    input  logic signed [mts_pkg::ENTRY_W-1:0] i_from_down,
    output logic signed [mts_pkg::ENTRY_W-1:0] o_entry
);
    import mts_pkg::*;

    logic signed [ENTRY_W-1:0] r_entry;
    logic signed [ENTRY_W-1:0] n_entry;

    always_comb begin
        priority if (i_ctl.push) begin
            n_entry = i_from_up;
        end else if (i_ctl.pop) begin
            n_entry = i_from_down;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* design/min_tracking_stack_core.sv */
// Top level of the min-tracking stack: control, minimum register and cell chain.
//
//  channel   direction  transaction moves
//  i_in      sink       mode, push_value
//  o_out     source     popped_value, current_minimum, entry_count, status
//  i_cfg_*   write      stack_capacity (9 bits)
//
// The cells shift on the accepting edge and the result is registered at the same
// edge, so one operation per cycle while the output register does not stall.
// The top of the stack always sits in cell 0, so no memory read is in the path.
// Reset empties the stack, loads the minimum register with the largest value
// and the capacity with 256; the cells themselves are not reset.
// A result held in the output register stalls the input until it is taken.
module min_tracking_stack_core #(
    parameter int DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mts_in_if.sink                      i_in,
    mts_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [mts_pkg::CNT_W-1:0]   i_cfg_wdata
);
    import mts_pkg::*;

    logic [CNT_W-1:0]         r_capacity;
    logic [CNT_W-1:0]         r_fill;
    logic [CNT_W-1:0]         n_fill;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] n_min;
    logic                     r_out_valid;
    t_out_item                r_out;
    t_out_item                n_out;

    logic                      w_accept;
    logic                      w_full;
    t_shift_ctl                w_ctl;
    logic signed [ENTRY_W-1:0] w_push_entry;
    logic signed [ENTRY_W-1:0] w_entry [DEPTH];
    logic signed [ENTRY_W-1:0] w_val;
    logic signed [ENTRY_W-1:0] w_min;
    logic signed [ENTRY_W-1:0] w_top;
    logic signed [ENTRY_W-1:0] w_restore;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Full when the fill level reaches the capacity or the physical depth.
    assign w_full = (32'(r_fill) >= DEPTH) || (r_fill >= r_capacity);

    assign w_val     = {{(ENTRY_W-DATA_W){i_in.data.push_value[DATA_W-1]}},
                        i_in.data.push_value};
    assign w_min     = {{(ENTRY_W-DATA_W){r_min[DATA_W-1]}}, r_min};
    assign w_top     = w_entry[0];
    assign w_restore = {w_min[ENTRY_W-2:0], 1'b0} - w_top;

    always_comb begin
        w_ctl        = '0;
        w_push_entry = w_val;
        n_fill       = r_fill;
        n_min        = r_min;
        n_out        = '0;
        n_out.status = ST_OK;
        unique case (i_in.data.mode)
            MODE_PUSH: begin
                if (w_full) begin
                    n_out.status = ST_OVERFLOW;
                end else begin
                    w_ctl.push = 1'b1;
                    n_fill     = r_fill + 1'b1;
                    if (r_fill == '0) begin
                        n_min = i_in.data.push_value;
                    end else if (w_val < w_min) begin
                        // Store the encoded entry so the old minimum can be recovered.
                        w_push_entry = {w_val[ENTRY_W-2:0], 1'b0} - w_min;
                        n_min        = i_in.data.push_value;
                    end
                end
            end
            MODE_POP: begin
                if (r_fill == '0) begin
                    n_out.status       = ST_UNDERFLOW;
                    n_out.popped_value = INT_MIN;
                end else begin
                    w_ctl.pop = 1'b1;
                    n_fill    = r_fill - 1'b1;
                    if (w_top < w_min) begin
                        n_out.popped_value = r_min;
                        n_min              = w_restore[DATA_W-1:0];
                    end else begin
                        n_out.popped_value = w_top[DATA_W-1:0];
                    end
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        n_out.current_minimum = (n_fill == '0) ? INT_MIN : n_min;
        n_out.entry_count     = n_fill;
        if (!w_accept) begin
            w_ctl = '0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [ENTRY_W-1:0] w_up;
            logic signed [ENTRY_W-1:0] w_down;
            if (g == 0) begin : g_first
                assign w_up = w_push_entry;
            end else begin : g_mid_up
                assign w_up = w_entry[g-1];
            end
            if (g == DEPTH-1) begin : g_last
                assign w_down = w_entry[g];
            end else begin : g_mid_down
                assign w_down = w_entry[g+1];
            end
            mts_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_from_up   (w_up),
                .i_from_down (w_down),
                .o_entry     (w_entry[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RESET;
            r_fill      <= '0;
            r_min       <= INT_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_fill      <= n_fill;
                r_min       <= n_min;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= DEPTH)
        else $error("fill level exceeds stack depth");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_fill) && $stable(r_min))
        else $error("stack state changed without a transaction");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.data.mode == MODE_PUSH && !w_full |=> r_fill == $past(r_fill) + 1'b1)
        else $error("accepted push did not raise the fill level");

    a_underflow_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_UNDERFLOW |->
            r_out.popped_value == INT_MIN && r_out.entry_count == '0)
        else $error("underflow result carries wrong value or count");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the min-tracking stack core.
module tb_top;
    import mts_pkg::*;

    localparam int STACK_DEPTH = 256;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        t_out_item                result;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    mts_in_if  req_ch ();
    mts_out_if res_ch ();

    min_tracking_stack_core #(
        .DEPTH (STACK_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_ch),
        .o_out       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the stack, its minimum and the capacity register.
    logic signed [ENTRY_W-1:0] stack_mem [STACK_DEPTH];
    int unsigned               fill_cnt;
    logic signed [DATA_W-1:0]  min_reg;
    logic [CNT_W-1:0]          cap_reg;

    t_out_item result_q [$];
    t_dir_row  dir_rows [$];

    // A directed row with a hand-typed result travels next to the transaction.
    bit        typed_flag;
    t_out_item typed_result;

    bit err_seen;
    int cycle_cnt;
    int burst_left;
    int stall_mode;
    int stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** min_tracking_stack_core: FAILED **");
            $finish;
        end
    end

    task automatic step_stack(input logic mode, input logic signed [DATA_W-1:0] value,
                              output t_out_item res);
        int unsigned              room;
        logic signed [ENTRY_W-1:0] entry;
        res = '0;
        res.status = ST_OK;
        room = (cap_reg > STACK_DEPTH) ? STACK_DEPTH : cap_reg;
        if (mode == MODE_PUSH) begin
            if (fill_cnt >= room || fill_cnt >= STACK_DEPTH) begin
                res.status = ST_OVERFLOW;
            end else if (fill_cnt == 0) begin
                min_reg = value;
                stack_mem[0] = ENTRY_W'(value);
                fill_cnt = 1;
            end else begin
                // A new minimum is stored encoded so the old one can be recovered.
                if (value < min_reg) begin
                    stack_mem[fill_cnt] = ENTRY_W'(2 * longint'(value) - longint'(min_reg));
                    min_reg = value;
                end else begin
                    stack_mem[fill_cnt] = ENTRY_W'(value);
                end
                fill_cnt++;
            end
        end else if (fill_cnt == 0) begin
            res.status = ST_UNDERFLOW;
            res.popped_value = INT_MIN;
        end else begin
            fill_cnt--;
            entry = stack_mem[fill_cnt];
            if (entry < min_reg) begin
                res.popped_value = min_reg;
                min_reg = DATA_W'(2 * longint'(min_reg) - longint'(entry));
            end else begin
                res.popped_value = entry[DATA_W-1:0];
            end
        end
        res.current_minimum = (fill_cnt == 0) ? INT_MIN : min_reg;
        res.entry_count = CNT_W'(fill_cnt);
    endtask

    task automatic compare_result(input t_out_item want, input t_out_item got);
        if (got.popped_value !== want.popped_value) begin
            $display("%0t: popped_value expected %0d, got %0d",
                     $time, want.popped_value, got.popped_value);
            err_seen = 1'b1;
        end
        if (got.current_minimum !== want.current_minimum) begin
            $display("%0t: current_minimum expected %0d, got %0d",
                     $time, want.current_minimum, got.current_minimum);
            err_seen = 1'b1;
        end
        if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d",
                     $time, want.entry_count, got.entry_count);
            err_seen = 1'b1;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, got.status);
            err_seen = 1'b1;
        end
    endtask

    // Request side: predict on every accepted transaction, track register writes.
    always @(posedge i_clk) begin
        t_out_item res;
        if (i_rst_n) begin
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (req_ch.valid && req_ch.ready) begin
                step_stack(req_ch.data.mode, req_ch.data.push_value, res);
                result_q.push_back(typed_flag ? typed_result : res);
            end
        end
    end

    // Result side: every accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d/%0d/%0d/%0d", $time,
                         res_ch.data.popped_value, res_ch.data.current_minimum,
                         res_ch.data.entry_count, res_ch.data.status);
                err_seen = 1'b1;
            end else begin
                compare_result(result_q.pop_front(), res_ch.data);
            end
        end
    end

    // The receiver switches between stall patterns, holding each for a random span.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 9) != 0);
            2: res_ch.ready <= ($urandom_range(0, 9) < 3);
            default: res_ch.ready <= cycle_cnt[1];
        endcase
    end

    task automatic send_item(input logic mode, input logic signed [DATA_W-1:0] value,
                             input bit typed, input t_out_item want);
        t_in_item item;
        int       gap;
        item.mode = mode;
        item.push_value = value;
        req_ch.valid <= 1'b1;
        req_ch.data <= item;
        typed_flag <= typed;
        typed_result <= want;
        do @(posedge i_clk); while (!req_ch.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 150);
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every outstanding result has been taken.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        longint near;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return INT_MIN;
            3: return INT_MAX;
            4: return ($urandom_range(0, 1) != 0) ? INT_MIN + 1 : INT_MAX - 1;
            5, 6: return $signed($urandom_range(0, 16)) - 8;
            default: begin
                // Close to the current minimum, mostly just below it.
                near = longint'(min_reg) - $urandom_range(0, 4) + 1;
                if (near < longint'(INT_MIN))
                    near = INT_MIN;
                if (near > longint'(INT_MAX))
                    near = INT_MAX;
                return near[DATA_W-1:0];
            end
        endcase
    endfunction

    task automatic run_phase(input logic [CNT_W-1:0] cap, input int n_items, input int push_pct);
        logic mode;
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        for (int i = 0; i < n_items; i++) begin
            mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
            send_item(mode, pick_value(), 1'b0, '0);
        end
    endtask

    function automatic void add_row(input logic mode, input logic signed [DATA_W-1:0] value,
                                    input bit typed, input logic signed [DATA_W-1:0] popped,
                                    input logic signed [DATA_W-1:0] minimum, input int count,
                                    input t_status st);
        t_dir_row row;
        row.mode = mode;
        row.value = value;
        row.typed = typed;
        row.result.popped_value = popped;
        row.result.current_minimum = minimum;
        row.result.entry_count = CNT_W'(count);
        row.result.status = st;
        dir_rows.push_back(row);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        typed_flag = 1'b0;
        typed_result = '0;
        err_seen = 1'b0;
        cycle_cnt = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        fill_cnt = 0;
        min_reg = INT_MAX;
        cap_reg = CAPACITY_RESET;

        // Extremes, the encoded minimum path, emptying pops and underflow.
        add_row(MODE_POP,  0,       1, INT_MIN, INT_MIN, 0, ST_UNDERFLOW);
        add_row(MODE_PUSH, INT_MAX, 1, 0,       INT_MAX, 1, ST_OK);
        add_row(MODE_PUSH, INT_MIN, 1, 0,       INT_MIN, 2, ST_OK);
        add_row(MODE_PUSH, INT_MIN, 1, 0,       INT_MIN, 3, ST_OK);
        add_row(MODE_POP,  0,       1, INT_MIN, INT_MIN, 2, ST_OK);
        add_row(MODE_POP,  0,       1, INT_MIN, INT_MAX, 1, ST_OK);
        add_row(MODE_POP,  0,       1, INT_MAX, INT_MIN, 0, ST_OK);
        add_row(MODE_POP,  0,       1, INT_MIN, INT_MIN, 0, ST_UNDERFLOW);
        add_row(MODE_PUSH, 0,       1, 0,       0,       1, ST_OK);
        add_row(MODE_PUSH, -1,      1, 0,       -1,      2, ST_OK);
        add_row(MODE_PUSH, 5,       1, 0,       -1,      3, ST_OK);
        add_row(MODE_PUSH, -1,      0, 0, 0, 0, ST_OK);
        add_row(MODE_PUSH, -100,    0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  -7,      0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  0,       0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  0,       0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  0,       0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  0,       0, 0, 0, 0, ST_OK);
        add_row(MODE_PUSH, 7,       1, 0,       7,       1, ST_OK);
        add_row(MODE_PUSH, INT_MAX - 1, 0, 0, 0, 0, ST_OK);
        add_row(MODE_PUSH, INT_MIN + 1, 0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  0,       0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  0,       0, 0, 0, 0, ST_OK);
        add_row(MODE_POP,  0,       0, 0, 0, 0, ST_OK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed,
                      dir_rows[i].result);

        run_phase(9'd0, 10, 50);
        run_phase(9'd1, 40, 50);
        // Capacity above the stack depth: fill up to the physical limit.
        run_phase(9'd511, 400, 85);
        run_phase(9'd511, 300, 20);
        // Capacity at the stack depth, then dropped to 3: pushes overflow until pops catch up.
        run_phase(9'd256, 200, 60);
        run_phase(9'd3, 200, 30);
        for (int p = 0; p < 4; p++)
            run_phase(($urandom_range(0, 1) != 0) ? CNT_W'($urandom_range(1, 12))
                                                  : CNT_W'($urandom_range(0, 511)),
                      125, 55);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (!err_seen)
            $display("** min_tracking_stack_core: PASSED **");
        else
            $display("** min_tracking_stack_core: FAILED **");
        $finish;
    end

endmodule
